FILE: design/cssm_pkg.sv
// shared types, codes and frame byte lookup for the checksummed spi register master
package cssm_pkg;

  localparam logic [1:0] OP_TICK  = 2'd0;

  localparam logic [1:0] KIND_IDLE  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;
  localparam logic [1:0] KIND_RESET = 2'd3;

  localparam logic [7:0] HDR_READ  = 8'h55;
  localparam logic [7:0] HDR_WRITE = 8'hA5;
  localparam logic [7:0] FILL_BYTE = 8'hFF;

  localparam logic [2:0] LAST_BYTE = 3'd5;
  localparam logic [2:0] MSB_BIT   = 3'd7;

  localparam logic [15:0] HPT_RESET = 16'd600;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  reg_address;
    logic [23:0] write_data;
    logic        sdo_in;
  } cssm_item_t;

  typedef struct packed {
    logic        sclk_out;
    logic        sdi_out;
    logic        busy_res;
    logic        frame_done;
    logic [23:0] read_data;
    logic        checksum_ok;
  } cssm_res_t;

  function automatic logic [7:0] frame_byte(
    input logic [1:0]  kind,
    input logic [2:0]  idx,
    input logic [7:0]  addr,
    input logic [23:0] wdata,
    input logic [7:0]  sum
  );
    logic [7:0] b;
    b = FILL_BYTE;
    unique case (kind)
      KIND_READ: begin
        if (idx == 3'd0) b = HDR_READ;
        else if (idx == 3'd1) b = addr;
      end
      KIND_WRITE: begin
        unique case (idx)
          3'd0:    b = HDR_WRITE;
          3'd1:    b = addr;
          3'd2:    b = wdata[23:16];
          3'd3:    b = wdata[15:8];
          3'd4:    b = wdata[7:0];
          3'd5:    b = ~sum;
          default: b = FILL_BYTE;
        endcase
      end
      default: b = FILL_BYTE;
    endcase
    return b;
  endfunction

endpackage

FILE: design/cssm_core.sv
// frame sequencer: bit timer, shift registers, checksum and read capture
module cssm_core import cssm_pkg::*; #(
  parameter int DIV_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  cssm_item_t item,
  input  logic [15:0] half_period_ticks,
  output cssm_res_t  res
);

  localparam int LW = 33;

  logic [DIV_BITS-1:0] tick_count, tick_count_next;
  logic [2:0]  bit_index, bit_index_next;
  logic [2:0]  byte_index, byte_index_next;
  logic [1:0]  frame_kind, frame_kind_next;
  logic        clock_phase_high, clock_phase_high_next;
  logic [7:0]  shift_out, shift_out_next;
  logic [7:0]  shift_in, shift_in_next;
  logic [7:0]  latched_address, latched_address_next;
  logic [23:0] latched_write_data, latched_write_data_next;
  logic [23:0] captured_data, captured_data_next;
  logic [7:0]  running_sum, running_sum_next;
  logic        check_result, check_result_next;

  logic [LW-1:0] lim, tick_inc, cap;
  logic          done;
  logic          busy;

  always_comb begin
    cap = LW'(1) << DIV_BITS;
    lim = LW'(half_period_ticks);
    if (lim == '0) lim = LW'(1);
    if (lim > cap) lim = cap;
    tick_inc = LW'(tick_count) + LW'(1);
  end

  always_comb begin
    tick_count_next         = tick_count;
    bit_index_next          = bit_index;
    byte_index_next         = byte_index;
    frame_kind_next         = frame_kind;
    clock_phase_high_next   = clock_phase_high;
    shift_out_next          = shift_out;
    shift_in_next           = shift_in;
    latched_address_next    = latched_address;
    latched_write_data_next = latched_write_data;
    captured_data_next      = captured_data;
    running_sum_next        = running_sum;
    check_result_next       = check_result;
    done                    = 1'b0;

    if (frame_kind == KIND_IDLE) begin
      if (item.opcode != OP_TICK) begin
        frame_kind_next         = item.opcode;
        latched_address_next    = item.reg_address;
        latched_write_data_next = item.write_data;
        byte_index_next         = 3'd0;
        bit_index_next          = MSB_BIT;
        clock_phase_high_next   = 1'b1;
        tick_count_next         = '0;
        shift_in_next           = 8'd0;
        if (item.opcode == KIND_READ) begin
          running_sum_next = HDR_READ + item.reg_address;
        end else if (item.opcode == KIND_WRITE) begin
          running_sum_next = HDR_WRITE + item.reg_address + item.write_data[23:16]
                           + item.write_data[15:8] + item.write_data[7:0];
        end else begin
          running_sum_next = 8'd0;
        end
        shift_out_next = frame_byte(item.opcode, 3'd0, item.reg_address,
                                    item.write_data, running_sum_next);
      end
    end else if (tick_inc < lim) begin
      tick_count_next = DIV_BITS'(tick_inc);
    end else begin
      tick_count_next = '0;
      if (clock_phase_high) begin
        clock_phase_high_next = 1'b0;
        if (item.sdo_in) shift_in_next = shift_in | (8'd1 << bit_index);
      end else if (bit_index != 3'd0) begin
        bit_index_next        = bit_index - 3'd1;
        clock_phase_high_next = 1'b1;
      end else begin
        // end of byte
        if (frame_kind == KIND_READ) begin
          if (byte_index >= 3'd2 && byte_index <= 3'd4) begin
            captured_data_next = {captured_data[15:0], shift_in};
            running_sum_next   = running_sum + shift_in;
          end else if (byte_index == LAST_BYTE) begin
            check_result_next = (shift_in == ~running_sum);
          end
        end
        if (byte_index >= LAST_BYTE) begin
          if (frame_kind != KIND_READ) check_result_next = 1'b1;
          frame_kind_next       = KIND_IDLE;
          clock_phase_high_next = 1'b0;
          shift_out_next        = FILL_BYTE;
          bit_index_next        = MSB_BIT;
          byte_index_next       = 3'd0;
          done                  = 1'b1;
        end else begin
          byte_index_next       = byte_index + 3'd1;
          bit_index_next        = MSB_BIT;
          clock_phase_high_next = 1'b1;
          shift_in_next         = 8'd0;
          shift_out_next        = frame_byte(frame_kind, byte_index + 3'd1,
                                             latched_address, latched_write_data,
                                             running_sum_next);
        end
      end
    end

    busy            = frame_kind_next != KIND_IDLE;
    res.sclk_out    = busy & clock_phase_high_next;
    res.sdi_out     = busy ? shift_out_next[bit_index_next] : 1'b1;
    res.busy_res    = busy;
    res.frame_done  = done;
    res.read_data   = captured_data_next;
    res.checksum_ok = check_result_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count         <= '0;
      bit_index          <= MSB_BIT;
      byte_index         <= 3'd0;
      frame_kind         <= KIND_IDLE;
      clock_phase_high   <= 1'b0;
      shift_out          <= FILL_BYTE;
      shift_in           <= 8'd0;
      latched_address    <= 8'd0;
      latched_write_data <= 24'd0;
      captured_data      <= 24'd0;
      running_sum        <= 8'd0;
      check_result       <= 1'b1;
    end else if (step) begin
      tick_count         <= tick_count_next;
      bit_index          <= bit_index_next;
      byte_index         <= byte_index_next;
      frame_kind         <= frame_kind_next;
      clock_phase_high   <= clock_phase_high_next;
      shift_out          <= shift_out_next;
      shift_in           <= shift_in_next;
      latched_address    <= latched_address_next;
      latched_write_data <= latched_write_data_next;
      captured_data      <= captured_data_next;
      running_sum        <= running_sum_next;
      check_result       <= check_result_next;
    end
  end

endmodule

FILE: design/cssm_outbuf.sv
// two-entry result buffer between the sequencer and the output stream
module cssm_outbuf import cssm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  cssm_res_t push_data,
  output logic      can_take,
  output logic      out_valid,
  input  logic      out_ready,
  output cssm_res_t out_data
);

  cssm_res_t   entry [2];
  logic        wr_ptr, rd_ptr;
  logic [1:0]  count;
  logic        pop;

  assign pop       = out_valid & out_ready;
  assign out_valid = count != 2'd0;
  assign can_take  = count != 2'd2;
  assign out_data  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

endmodule

FILE: design/checksummed_spi_register_master.sv
// top level: input register, frame sequencer, result buffer and config register
// an accepted transaction is registered, then its result is buffered for m_axis
// throughput: one tick transaction per cycle while the result buffer has room
// results are held in a two-entry buffer, so input keeps flowing while one result waits
// reset: synchronous, clears the sequencer to idle, empties the buffer, period back to 600
module checksummed_spi_register_master import cssm_pkg::*; #(
  parameter int DIV_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,      // half_period_ticks
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // reg_address[7:0], write_data[31:8], sdo_in[32]
  input  logic [1:0]  s_axis_tuser,  // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // sclk_out, sdi_out, busy_res, read_data, checksum_ok
  output logic        m_axis_tlast   // frame_done
);

  logic [15:0] half_period_ticks;
  logic        in_valid;
  cssm_item_t  in_item;
  logic        step;
  logic        buf_can_take;
  cssm_res_t   core_res;
  cssm_res_t   out_res;

  assign cfg_ready     = 1'b1;
  assign step          = in_valid & buf_can_take;
  assign s_axis_tready = ~in_valid | step;

  always_ff @(posedge clk) begin
    if (rst) half_period_ticks <= HPT_RESET;
    else if (cfg_valid) half_period_ticks <= cfg_data;
  end

  always_ff @(posedge clk) begin
    if (rst) in_valid <= 1'b0;
    else if (s_axis_tready) in_valid <= s_axis_tvalid;
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.opcode      <= s_axis_tuser;
      in_item.reg_address <= s_axis_tdata[7:0];
      in_item.write_data  <= s_axis_tdata[31:8];
      in_item.sdo_in      <= s_axis_tdata[32];
    end
  end

  cssm_core #(.DIV_BITS(DIV_BITS)) u_core (
    .clk               (clk),
    .rst               (rst),
    .step              (step),
    .item              (in_item),
    .half_period_ticks (half_period_ticks),
    .res               (core_res)
  );

  cssm_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (step),
    .push_data (core_res),
    .can_take  (buf_can_take),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_res)
  );

  assign m_axis_tdata = {4'd0, out_res.checksum_ok, out_res.read_data,
                         out_res.busy_res, out_res.sdi_out, out_res.sclk_out};
  assign m_axis_tlast = out_res.frame_done;

  a_idle_pins: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[2] |-> !m_axis_tdata[0] && m_axis_tdata[1])
    else $error("idle result drives sclk or sdi away from idle level");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> !m_axis_tdata[2])
    else $error("frame done reported while still busy");

  a_item_held: assert property (@(posedge clk) disable iff (rst)
    in_valid && !step |=> in_valid && $stable(in_item))
    else $error("stalled input item lost or changed");

  a_step_has_room: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready && !buf_can_take |=> m_axis_tvalid)
    else $error("full result buffer emptied without a transaction");

endmodule
